@@ design/lfu_replacement_unit_defines.svh @@
// assertion macros for the lfu replacement unit checker
// expects aclk and aresetn in the scope where a macro is used
`ifndef LFU_REPLACEMENT_UNIT_DEFINES_SVH
`define LFU_REPLACEMENT_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LFU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LFU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lfu_pkg.sv @@
// shared types and constants for the lfu replacement unit
// no dependencies
package lfu_pkg;

    localparam int FUNC_W = 2;
    localparam int ADDR_W = 16;
    localparam int WAY_W  = 2;
    localparam int CNT_W  = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

    // request operation codes
    typedef enum logic [FUNC_W-1:0] {
        OP_VICTIM = 2'd0,
        OP_HIT    = 2'd1,
        OP_INVAL  = 2'd2
    } lfu_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } lfu_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic wr_en;
        logic out_load;
    } lfu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_victim;
        logic is_write;
    } lfu_sts_t;

endpackage

@@ design/lfu_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/lfu_ctrl.sv @@
// control state machine for the lfu replacement unit
// depends on lfu_pkg
module lfu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output lfu_pkg::lfu_cmd_t cmd,
    input  lfu_pkg::lfu_sts_t sts
);
    import lfu_pkg::*;

    lfu_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        s_ready        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.is_victim) begin
                    // hold until the output register is free
                    if (!out_valid_reg || m_ready) begin
                        cmd.out_load   = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    cmd.wr_en  = sts.is_write;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

@@ design/lfu_dp.sv @@
// datapath: counter store, row update and minimum search
// depends on lfu_pkg and lfu_ram
module lfu_dp #(
    parameter int WAYS        = 4,
    parameter int INDEX_BITS  = 4,
    parameter int OFFSET_BITS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lfu_pkg::FUNC_W-1:0]  s_func,
    input  logic [lfu_pkg::ADDR_W-1:0]  s_address,
    input  logic [lfu_pkg::WAY_W-1:0]   s_way,
    output logic [lfu_pkg::WAY_W-1:0]   m_victim_way,
    input  lfu_pkg::lfu_cmd_t           cmd,
    output lfu_pkg::lfu_sts_t           sts
);
    import lfu_pkg::*;

    localparam int SETS  = 1 << INDEX_BITS;
    localparam int ROW_W = WAYS * CNT_W;
    localparam int WB    = $clog2(WAYS);
    localparam int P     = 1 << WB;

    logic [INDEX_BITS-1:0] s_set;
    logic [FUNC_W-1:0]     func_reg;
    logic [WAY_W-1:0]      way_reg;
    logic [INDEX_BITS-1:0] set_reg;
    logic                  row_valid_reg [SETS];
    logic                  rd_valid_reg;
    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      cur_row;
    logic [ROW_W-1:0]      wr_row;
    logic [CNT_W-1:0]      lane_cnt [WAYS];
    logic [CNT_W-1:0]      node_cnt [2*P];
    logic [WB-1:0]         node_idx [2*P];
    logic [WAY_W-1:0]      victim_reg;

    assign s_set = s_address[OFFSET_BITS +: INDEX_BITS];

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_func;
            way_reg  <= s_way;
            set_reg  <= s_set;
        end
    end

    // per-set valid bits, a row never written reads as all zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SETS; i++) begin
                row_valid_reg[i] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
        end else begin
            if (cmd.wr_en) begin
                row_valid_reg[set_reg] <= 1'b1;
            end
            if (cmd.capture) begin
                rd_valid_reg <= row_valid_reg[s_set];
            end
        end
    end

    // counter rows, one per set
    lfu_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (set_reg),
        .wr_data (wr_row),
        .rd_en   (cmd.capture),
        .rd_addr (s_set),
        .rd_data (rd_row)
    );

    assign cur_row = rd_valid_reg ? rd_row : '0;

    // split row into lanes and build the updated row
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            lane_cnt[i]                = cur_row[i*CNT_W +: CNT_W];
            wr_row[i*CNT_W +: CNT_W]   = lane_cnt[i];
            if (int'(way_reg) == i) begin
                if (func_reg == OP_HIT) begin
                    if (lane_cnt[i] != COUNT_MAX) begin
                        wr_row[i*CNT_W +: CNT_W] = lane_cnt[i] + CNT_W'(1);
                    end
                end else begin
                    wr_row[i*CNT_W +: CNT_W] = '0;
                end
            end
        end
    end

    // minimum search tree, ties go to the lower way
    always_comb begin
        node_cnt[0] = '0;
        node_idx[0] = '0;
        for (int k = 0; k < P; k++) begin
            node_cnt[P+k] = (k < WAYS) ? lane_cnt[k] : COUNT_MAX;
            node_idx[P+k] = WB'(k);
        end
        for (int k = P - 1; k >= 1; k--) begin
            if (node_cnt[2*k+1] < node_cnt[2*k]) begin
                node_cnt[k] = node_cnt[2*k+1];
                node_idx[k] = node_idx[2*k+1];
            end else begin
                node_cnt[k] = node_cnt[2*k];
                node_idx[k] = node_idx[2*k];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            victim_reg <= WAY_W'(node_idx[1]);
        end
    end

    assign m_victim_way  = victim_reg;
    assign sts.is_victim = (func_reg == OP_VICTIM);
    assign sts.is_write  = (func_reg == OP_HIT) || (func_reg == OP_INVAL);

endmodule

@@ design/lfu_replacement_unit.sv @@
// top level of the lfu replacement unit
// depends on lfu_pkg, lfu_ctrl, lfu_dp
//
//  channel | ports                               | moves
//  s_      | s_valid s_ready s_func s_address s_way | one request
//  m_      | m_valid m_ready m_victim_way        | victim way of a find-victim request
//
// each request is accepted with the row read, then updates the row or searches it
// the counter row is read through a registered port, one request at a time
// reset clears all counters at once through per-set valid bits, no sweep
// a find-victim request waits in the exec state while the result is unread
module lfu_replacement_unit #(
    parameter int WAYS        = 4,
    parameter int INDEX_BITS  = 4,
    parameter int OFFSET_BITS = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [lfu_pkg::FUNC_W-1:0] s_func,
    input  logic [lfu_pkg::ADDR_W-1:0] s_address,
    input  logic [lfu_pkg::WAY_W-1:0]  s_way,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lfu_pkg::WAY_W-1:0]  m_victim_way
);
    import lfu_pkg::*;

    lfu_cmd_t cmd;
    lfu_sts_t sts;

    // controller
    lfu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath
    lfu_dp #(
        .WAYS        (WAYS),
        .INDEX_BITS  (INDEX_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_func       (s_func),
        .s_address    (s_address),
        .s_way        (s_way),
        .m_victim_way (m_victim_way),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

@@ design/lfu_checker.sv @@
// port-level checks for the lfu replacement unit, bound to the top level
// depends on lfu_pkg and lfu_replacement_unit_defines.svh
`include "lfu_replacement_unit_defines.svh"

module lfu_port_checks (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [lfu_pkg::FUNC_W-1:0] s_func,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [lfu_pkg::WAY_W-1:0]  m_victim_way
);
    import lfu_pkg::*;

    logic acc_victim;
    logic acc_update;

    // requests accepted while the output is empty
    assign acc_victim = s_valid && s_ready && (s_func == OP_VICTIM) && !m_valid;
    assign acc_update = s_valid && s_ready && ((s_func == OP_HIT) || (s_func == OP_INVAL))
                        && !m_valid;

    // a stalled result holds
    `LFU_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_victim_way), "result changed")

    // one request at a time
    `LFU_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "accepted while busy")

    // a find-victim request accepted into an empty output gives a result
    `LFU_ASSERT_IMP(a_victim_result, acc_victim, ##2 m_valid, "no victim result")

    // hit and invalidate requests give no result
    `LFU_ASSERT_IMP(a_no_result, acc_update, ##2 !m_valid, "update gave a result")

endmodule

bind lfu_replacement_unit lfu_port_checks u_chk (.*);

@@ tb/lfu_checker.sv @@
// checker for the lfu replacement unit: tracks the use counters, predicts victim ways
// depends on lfu_pkg; hands its mismatch and outstanding counts to the testbench top
module lfu_checker #(
    parameter int WAYS        = 4,
    parameter int INDEX_BITS  = 4,
    parameter int OFFSET_BITS = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [lfu_pkg::FUNC_W-1:0] s_func,
    input  logic [lfu_pkg::ADDR_W-1:0] s_address,
    input  logic [lfu_pkg::WAY_W-1:0]  s_way,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [lfu_pkg::WAY_W-1:0]  m_victim_way,
    output int                         mismatches,
    output int                         outstanding
);
    import lfu_pkg::*;

    localparam int SETS = 1 << INDEX_BITS;

    // shadow copy of the per-set, per-way use counters
    logic [CNT_W-1:0] use_cnt [SETS][WAYS];
    // victim ways still owed by the block, oldest first
    logic [WAY_W-1:0] victim_q [$];

    // lowest way holding the smallest counter of a set
    function automatic logic [WAY_W-1:0] lfu_victim(input int set_idx);
        int               best;
        logic [CNT_W-1:0] low;
        best = 0;
        low  = use_cnt[set_idx][0];
        for (int i = 1; i < WAYS; i++) begin
            if (use_cnt[set_idx][i] < low) begin
                low  = use_cnt[set_idx][i];
                best = i;
            end
        end
        return best[WAY_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        int               set_idx;
        int               way_idx;
        logic [WAY_W-1:0] exp_way;
        if (!aresetn) begin
            foreach (use_cnt[s, w]) use_cnt[s][w] = '0;
            victim_q.delete();
        end else begin
            // results first: a request accepted at this edge cannot answer yet
            if (m_valid && m_ready) begin
                if (victim_q.size() == 0) begin
                    report_mismatch($sformatf("victim way %0d with no request waiting",
                                              m_victim_way));
                end else begin
                    exp_way = victim_q.pop_front();
                    if (m_victim_way !== exp_way)
                        report_mismatch($sformatf("victim way %0d, expected %0d",
                                                  m_victim_way, exp_way));
                end
            end
            // update the counters for an accepted request
            if (s_valid && s_ready) begin
                set_idx = (int'(s_address) >> OFFSET_BITS) & (SETS - 1);
                way_idx = int'(s_way);
                if (s_func == OP_VICTIM) begin
                    victim_q.push_back(lfu_victim(set_idx));
                end else if (way_idx < WAYS) begin
                    if (s_func == OP_HIT) begin
                        // saturating increment
                        if (use_cnt[set_idx][way_idx] < COUNT_MAX)
                            use_cnt[set_idx][way_idx] = use_cnt[set_idx][way_idx] + 1'b1;
                    end else if (s_func == OP_INVAL) begin
                        use_cnt[set_idx][way_idx] = '0;
                    end
                end
            end
        end
        outstanding = victim_q.size();
    end

endmodule

@@ tb/tb_lfu_replacement_unit.sv @@
// testbench top for the lfu replacement unit: clock, reset, requests and result stalls
// depends on lfu_pkg, lfu_replacement_unit and lfu_checker
module tb_lfu_replacement_unit;
    import lfu_pkg::*;

    localparam int WAYS        = 4;
    localparam int INDEX_BITS  = 4;
    localparam int OFFSET_BITS = 4;
    localparam int SETS        = 1 << INDEX_BITS;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 30;
    localparam int DRAIN_CYCLES = 10;
    localparam int SAT_ITEMS    = 290;
    localparam int RAND_ITEMS   = 360;

    // operation code the block does not define
    localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [FUNC_W-1:0] s_func    = OP_VICTIM;
    logic [ADDR_W-1:0] s_address = '0;
    logic [WAY_W-1:0]  s_way     = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [WAY_W-1:0]  m_victim_way;

    int mismatches;
    int outstanding;
    int cycles    = 0;
    bit send_rush = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    lfu_replacement_unit #(
        .WAYS        (WAYS),
        .INDEX_BITS  (INDEX_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_address    (s_address),
        .s_way        (s_way),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_victim_way (m_victim_way)
    );

    lfu_checker #(
        .WAYS        (WAYS),
        .INDEX_BITS  (INDEX_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_address    (s_address),
        .s_way        (s_way),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_victim_way (m_victim_way),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // random address whose index bits select the given set
    function automatic logic [ADDR_W-1:0] addr_in_set(input int set_idx);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
        a[OFFSET_BITS +: INDEX_BITS] = set_idx[INDEX_BITS-1:0];
        return a;
    endfunction

    // offer one request after a random gap, return at the falling edge after acceptance
    task automatic send_request(input logic [FUNC_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                input logic [WAY_W-1:0] way_sel);
        int gap;
        if ($urandom_range(0, 39) == 0) send_rush = !send_rush;
        gap = send_rush ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= op;
        s_address <= addr;
        s_way     <= way_sel;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // result side: random stalls, one long hold-off so the block backs up
    initial begin : result_sink
        int gap;
        int taken;
        bit rush;
        taken = 0;
        rush  = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 19) == 0) rush = !rush;
            gap = rush ? 0 : $urandom_range(0, 13);
            if (taken == HOLD_AT) gap = HOLD_CYCLES;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int                hot_set;
        int                sat_set;
        int                set_idx;
        int                pick;
        logic [WAY_W-1:0]  sat_way;
        logic [FUNC_W-1:0] op;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: fresh sets, address extremes, every operation, ties
        send_request(OP_VICTIM, 16'h0000, 2'd3);
        send_request(OP_VICTIM, 16'hFFFF, 2'd0);
        send_request(OP_HIT,    16'hFFFF, 2'd0);
        send_request(OP_VICTIM, 16'hFFF0, 2'd0);
        send_request(OP_HIT,    16'h00F5, 2'd1);
        send_request(OP_HIT,    16'hA0FA, 2'd2);
        send_request(OP_VICTIM, 16'h55F3, 2'd1);
        send_request(OP_HIT,    16'hFFFF, 2'd3);
        send_request(OP_VICTIM, 16'hFFFF, 2'd2);
        send_request(OP_INVAL,  16'h0FF0, 2'd2);
        send_request(OP_VICTIM, 16'hFFFF, 2'd0);
        // unused code must leave the set alone
        send_request(OP_UNUSED, 16'hFFFF, 2'd2);
        send_request(OP_UNUSED, 16'h0000, 2'd3);
        send_request(OP_VICTIM, 16'hFFFF, 2'd3);
        // offset bits outside the index do not change the set
        send_request(OP_HIT,    16'h000F, 2'd3);
        send_request(OP_HIT,    16'hFF0F, 2'd0);
        send_request(OP_VICTIM, 16'h8000, 2'd0);
        send_request(OP_INVAL,  16'h0000, 2'd3);
        send_request(OP_VICTIM, 16'h0001, 2'd1);
        send_request(OP_VICTIM, 16'h0010, 2'd0);

        // hammer one way past the counter ceiling, probing the set now and then
        sat_set = $urandom_range(0, SETS - 1);
        sat_way = WAY_W'($urandom_range(0, WAYS - 1));
        for (int i = 0; i < SAT_ITEMS; i++) begin
            if (i % 16 == 15)
                send_request(OP_VICTIM, addr_in_set(sat_set),
                             WAY_W'($urandom_range(0, 3)));
            else
                send_request(OP_HIT, addr_in_set(sat_set), sat_way);
        end
        send_request(OP_VICTIM, addr_in_set(sat_set), sat_way);
        send_request(OP_INVAL,  addr_in_set(sat_set), sat_way);
        send_request(OP_VICTIM, addr_in_set(sat_set), sat_way);

        // random mix, half of it on one hot set so counters diverge
        hot_set = $urandom_range(0, SETS - 1);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if ($urandom_range(0, 49) == 0) hot_set = $urandom_range(0, SETS - 1);
            set_idx = ($urandom_range(0, 1) == 0) ? hot_set : $urandom_range(0, SETS - 1);
            pick    = $urandom_range(0, 19);
            if (pick < 6)
                op = OP_VICTIM;
            else if (pick < 14)
                op = OP_HIT;
            else if (pick < 18)
                op = OP_INVAL;
            else
                op = OP_UNUSED;
            send_request(op, addr_in_set(set_idx), WAY_W'($urandom_range(0, 3)));
        end
        s_valid <= 1'b0;

        // let the last results drain
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
